@@ hdl/hcbd_pkg.sv @@
// Shared types, codes and byte constants for the chunked body decoder.
package hcbd_pkg;

	// Result status codes
	localparam logic [1:0] STATUS_MORE = 2'd0;
	localparam logic [1:0] STATUS_DONE = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	typedef enum logic [4:0] {
		PH_SIZE = 5'b00001,
		PH_DATA = 5'b00010,
		PH_CRLF = 5'b00100,
		PH_DONE = 5'b01000,
		PH_BAD  = 5'b10000
	} phase_t;

	typedef enum logic [7:0] {
		SS_WS        = 8'b00000001,
		SS_SIGN      = 8'b00000010,
		SS_ZERO      = 8'b00000100,
		SS_PREFIX    = 8'b00001000,
		SS_DIGITS    = 8'b00010000,
		SS_END_DIG   = 8'b00100000,
		SS_END_NODIG = 8'b01000000,
		SS_OVERFLOW  = 8'b10000000
	} size_step_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_valid;
		logic [1:0] status;
	} hcbd_result_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
	endfunction

endpackage

@@ hdl/hcbd_size_parse.sv @@
// Next-state logic of the hex chunk-size line parser, one byte per call.
module hcbd_size_parse
	import hcbd_pkg::*;
#(
	parameter int SIZE_WIDTH = 32
) (
	input  logic [7:0]            byte_in,
	input  size_step_t            step,
	input  logic                  neg,
	input  logic [SIZE_WIDTH-1:0] accum,
	output size_step_t            step_nxt,
	output logic                  neg_nxt,
	output logic [SIZE_WIDTH-1:0] accum_nxt
);

	logic [4:0]            hex;
	logic                  ovf;
	size_step_t            dig_step;
	logic [SIZE_WIDTH-1:0] dig_accum;

	assign hex = hex_decode(byte_in);

	// shifting in a nibble overflows only if the top nibble is already in use
	assign ovf       = |accum[SIZE_WIDTH-1 -: 4];
	assign dig_step  = ovf ? SS_OVERFLOW : SS_DIGITS;
	assign dig_accum = ovf ? accum : {accum[SIZE_WIDTH-5:0], hex[3:0]};

	always_comb begin
		step_nxt  = step;
		neg_nxt   = neg;
		accum_nxt = accum;
		case (step)
			SS_WS: begin
				if (is_space(byte_in)) begin
					step_nxt = SS_WS;
				end else if (byte_in == CH_PLUS || byte_in == CH_MINUS) begin
					neg_nxt  = (byte_in == CH_MINUS);
					step_nxt = SS_SIGN;
				end else if (byte_in == CH_ZERO) begin
					step_nxt = SS_ZERO;
				end else if (hex[4]) begin
					step_nxt  = dig_step;
					accum_nxt = dig_accum;
				end else begin
					step_nxt = SS_END_NODIG;
				end
			end
			SS_SIGN: begin
				if (byte_in == CH_ZERO) begin
					step_nxt = SS_ZERO;
				end else if (hex[4]) begin
					step_nxt  = dig_step;
					accum_nxt = dig_accum;
				end else begin
					step_nxt = SS_END_NODIG;
				end
			end
			SS_ZERO: begin
				if (byte_in == CH_LC_X || byte_in == CH_UC_X) begin
					step_nxt = SS_PREFIX;
				end else if (hex[4]) begin
					step_nxt  = dig_step;
					accum_nxt = dig_accum;
				end else begin
					step_nxt = SS_END_DIG;
				end
			end
			SS_PREFIX, SS_DIGITS: begin
				if (hex[4]) begin
					step_nxt  = dig_step;
					accum_nxt = dig_accum;
				end else begin
					step_nxt = SS_END_DIG;
				end
			end
			default: begin
				step_nxt = step;
			end
		endcase
	end

endmodule

@@ hdl/hcbd_core.sv @@
// Decoder state registers and per-byte phase logic.
module hcbd_core
	import hcbd_pkg::*;
#(
	parameter int LINE_LIMIT = 64,
	parameter int SIZE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic [7:0]   byte_in,
	output hcbd_result_t result
);

	localparam int LCW = $clog2(LINE_LIMIT);

	phase_t                phase_q,      phase_nxt;
	logic [SIZE_WIDTH-1:0] bytes_left_q, bytes_left_nxt;
	logic [LCW-1:0]        line_count_q, line_count_nxt;
	logic [SIZE_WIDTH-1:0] accum_q,      accum_nxt;
	size_step_t            step_q,       step_nxt;
	logic                  neg_q,        neg_nxt;
	logic                  cr_q,         cr_nxt;

	size_step_t            p_step;
	logic                  p_neg;
	logic [SIZE_WIDTH-1:0] p_accum;
	logic                  has_digits;

	hcbd_size_parse #(
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_parse (
		.byte_in   (byte_in),
		.step      (step_q),
		.neg       (neg_q),
		.accum     (accum_q),
		.step_nxt  (p_step),
		.neg_nxt   (p_neg),
		.accum_nxt (p_accum)
	);

	assign has_digits = step_q == SS_ZERO || step_q == SS_PREFIX ||
		step_q == SS_DIGITS || step_q == SS_END_DIG;

	always_comb begin
		phase_nxt         = phase_q;
		bytes_left_nxt    = bytes_left_q;
		line_count_nxt    = line_count_q;
		accum_nxt         = accum_q;
		step_nxt          = step_q;
		neg_nxt           = neg_q;
		cr_nxt            = cr_q;
		result.body_byte  = 8'd0;
		result.body_valid = 1'b0;
		case (phase_q)
			PH_SIZE: begin
				if (byte_in == CH_LF) begin
					if (!has_digits || (neg_q && accum_q != '0)) begin
						phase_nxt = PH_BAD;
					end else if (accum_q == '0) begin
						phase_nxt = PH_DONE;
					end else begin
						bytes_left_nxt = accum_q;
						phase_nxt      = PH_DATA;
					end
					line_count_nxt = '0;
					accum_nxt      = '0;
					step_nxt       = SS_WS;
					neg_nxt        = 1'b0;
				end else if (line_count_q >= LCW'(LINE_LIMIT - 1)) begin
					phase_nxt = PH_BAD;
				end else begin
					line_count_nxt = line_count_q + LCW'(1);
					step_nxt       = p_step;
					neg_nxt        = p_neg;
					accum_nxt      = p_accum;
				end
			end
			PH_DATA: begin
				result.body_byte  = byte_in;
				result.body_valid = 1'b1;
				bytes_left_nxt    = bytes_left_q - SIZE_WIDTH'(1);
				if (bytes_left_q == SIZE_WIDTH'(1)) begin
					phase_nxt = PH_CRLF;
					cr_nxt    = 1'b0;
				end
			end
			PH_CRLF: begin
				if (byte_in == CH_CR) begin
					cr_nxt = 1'b1;
				end else if (byte_in == CH_LF && cr_q) begin
					phase_nxt = PH_SIZE;
					cr_nxt    = 1'b0;
				end else begin
					phase_nxt = PH_BAD;
				end
			end
			default: begin
				phase_nxt = phase_q;
			end
		endcase

		case (phase_nxt)
			PH_DONE:                   result.status = STATUS_DONE;
			PH_SIZE, PH_DATA, PH_CRLF: result.status = STATUS_MORE;
			default:                   result.status = STATUS_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			bytes_left_q <= '0;
			line_count_q <= '0;
			accum_q      <= '0;
			step_q       <= SS_WS;
			neg_q        <= 1'b0;
			cr_q         <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_nxt;
			bytes_left_q <= bytes_left_nxt;
			line_count_q <= line_count_nxt;
			accum_q      <= accum_nxt;
			step_q       <= step_nxt;
			neg_q        <= neg_nxt;
			cr_q         <= cr_nxt;
		end
	end

endmodule

@@ hdl/http_chunked_body_decoder.sv @@
// Chunked transfer body decoder top level: input register, decoder core, result register.
//
//  channel  handshake             payload
//  input    in_valid / in_ready   in_byte
//  output   out_valid / out_ready body_byte, body_valid, status
//
// One item per cycle sustained while out_ready stays high; an accepted item
// passes through the input register, then the result register, to the outputs.
// The decoder state is updated in the core as the item moves from the input
// register to the result register, so a new item can enter as one leaves.
// Reset returns the decoder to the start of a size line with no items held.
// With out_ready low the result holds, the input register still takes one
// item, and in_ready then falls until the result is taken.
module http_chunked_body_decoder
	import hcbd_pkg::*;
#(
	parameter int LINE_LIMIT = 64,
	parameter int SIZE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] body_byte,
	output logic       body_valid,
	output logic [1:0] status
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         fire_s1;
	logic         valid_s2;
	hcbd_result_t result_s2;
	hcbd_result_t res;

	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	hcbd_core #(
		.LINE_LIMIT (LINE_LIMIT),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (fire_s1),
		.byte_in (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign body_byte  = result_s2.body_byte;
	assign body_valid = result_s2.body_valid;
	assign status     = result_s2.status;

	// payload only ever appears while the body is still open
	a_body_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && body_valid) |-> (status == STATUS_MORE))
		else $error("body item with terminal status");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !body_valid) |-> (body_byte == 8'd0))
		else $error("non-body item carries a byte");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_DONE) |=> (!out_valid || status == STATUS_DONE))
		else $error("done status not held");

	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_BAD) |=> (!out_valid || status == STATUS_BAD))
		else $error("malformed status not held");

endmodule
